### src/auto_ranging_level_meter_assert.svh
// assertion macros for the auto-ranging level meter
// expects clk and rst_n in the scope where a macro is used
`ifndef AUTO_RANGING_LEVEL_METER_ASSERT_SVH
`define AUTO_RANGING_LEVEL_METER_ASSERT_SVH

// same-cycle implication, held off during reset
`define ARLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define ARLM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/arlm_pkg.sv
// shared widths, register indexes and reset values of the level meter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package arlm_pkg;

  // field and register widths
  localparam int SAMPLE_W = 10;
  localparam int HEIGHT_W = 10;
  localparam int RATE_W   = 16;
  localparam int WLEN_W   = 7;
  localparam int OFS_W    = 10;
  localparam int FLOOR_W  = 10;
  localparam int LEVEL_W  = 16;
  localparam int WIN_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // divider: positive numerator is below 2^26
  localparam int DIV_W   = 26;
  localparam int DCNT_W  = 5;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t CFG_MAX_HEIGHT     = 3'd0;
  localparam cfg_idx_t CFG_PEAK_FALL_RATE = 3'd1;
  localparam cfg_idx_t CFG_WINDOW_LENGTH  = 3'd2;
  localparam cfg_idx_t CFG_DC_OFFSET      = 3'd3;
  localparam cfg_idx_t CFG_NOISE_FLOOR    = 3'd4;

  // reset values
  localparam int MAX_HEIGHT_RST = 62;
  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT_INIT  = 10'(MAX_HEIGHT_RST);
  localparam logic [RATE_W-1:0]   FALL_RATE_INIT   = 16'd8;
  localparam logic [WLEN_W-1:0]   WINDOW_LEN_INIT  = 7'd60;
  localparam logic [LEVEL_W-1:0]  LEVEL_INIT       = 16'(MAX_HEIGHT_RST / 3);
  localparam logic [LEVEL_W-1:0]  AVG_HIGH_INIT    = 16'd512;

  // mid-scale of the converter
  localparam logic signed [11:0] ADC_MID = 12'sd512;

endpackage

`default_nettype wire

### src/auto_ranging_level_meter.sv
// auto-ranging level meter with peak hold: window memory, serial divider, control
// depends on arlm_pkg and auto_ranging_level_meter_assert.svh
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+------------------------------------
//   in      | input     | in_valid/in_stall | in_adc_sample
//   out     | output    | out_valid/out_stall | out_bar_height, out_peak_height
//   cfg     | input     | cfg_we            | cfg_index, cfg_wdata
//
// a new item is accepted only after the previous one has left the finishing step;
// the scan of the window memory over the effective window length (one read
// a cycle) runs side by side with the 26-step restoring divider
// after reset the window memory is cleared one entry a cycle with in_stall high;
// configuration writes are taken meanwhile
// a result waits in the output register; a new item is taken while it waits
`timescale 1ns / 1ps
`default_nettype none
`include "auto_ranging_level_meter_assert.svh"

module auto_ranging_level_meter
  import arlm_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // input items
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [SAMPLE_W-1:0]   in_adc_sample,
  // result items
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [HEIGHT_W-1:0]        out_bar_height,
  output logic [HEIGHT_W-1:0]        out_peak_height
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int LW = (CW > WLEN_W) ? CW : WLEN_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LEVEL, S_MUL, S_LOAD, S_RUN, S_FIN
  } state_t;

  state_t state_r;

  // configuration registers
  logic [HEIGHT_W-1:0] max_height_r;
  logic [RATE_W-1:0]   fall_rate_r;
  logic [WLEN_W-1:0]   window_length_r;
  logic [OFS_W-1:0]    dc_offset_r;
  logic [FLOOR_W-1:0]  noise_floor_r;

  // meter state
  logic [LEVEL_W-1:0]  level_r;
  logic [LEVEL_W-1:0]  avg_low_r;
  logic [LEVEL_W-1:0]  avg_high_r;
  logic [HEIGHT_W-1:0] peak_dot_r;
  logic [RATE_W-1:0]   fall_cnt_r;
  logic [AW-1:0]       write_idx_r;
  logic [AW-1:0]       clr_idx_r;

  // per-item working registers
  logic [SAMPLE_W-1:0] reading_r;
  logic signed [27:0]  num_r;
  logic signed [16:0]  den_r;
  logic [15:0]         rem_r;
  logic [DIV_W-1:0]    quo_r;
  logic [DCNT_W-1:0]   div_cnt_r;
  logic [LW-1:0]       scan_idx_r;
  logic                rd_pend_r;
  logic                scan_first_r;
  logic [WIN_W-1:0]    lo_r;
  logic [WIN_W-1:0]    hi_r;

  // output register
  logic                out_valid_r;
  logic [HEIGHT_W-1:0] out_bar_r;
  logic [HEIGHT_W-1:0] out_peak_r;

  // window memory
  logic [WIN_W-1:0] win_mem [MAX_WINDOW];
  logic [WIN_W-1:0] mem_q_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [WIN_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;

  // handshake outputs
  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_bar_height  = out_bar_r;
  assign out_peak_height = out_peak_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_height_r    <= MAX_HEIGHT_INIT;
      fall_rate_r     <= FALL_RATE_INIT;
      window_length_r <= WINDOW_LEN_INIT;
      dc_offset_r     <= '0;
      noise_floor_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_HEIGHT:     max_height_r    <= cfg_wdata[HEIGHT_W-1:0];
        CFG_PEAK_FALL_RATE: fall_rate_r     <= cfg_wdata[RATE_W-1:0];
        CFG_WINDOW_LENGTH:  window_length_r <= cfg_wdata[WLEN_W-1:0];
        CFG_DC_OFFSET:      dc_offset_r     <= cfg_wdata[OFS_W-1:0];
        CFG_NOISE_FLOOR:    noise_floor_r   <= cfg_wdata[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  // effective window length, clamped to 1..MAX_WINDOW
  logic [LW-1:0] wlen_ext;
  logic [LW-1:0] eff_len;
  always_comb begin
    wlen_ext = LW'(window_length_r);
    if (wlen_ext == '0) begin
      eff_len = LW'(1);
    end else if (wlen_ext > LW'(MAX_WINDOW)) begin
      eff_len = LW'(MAX_WINDOW);
    end else begin
      eff_len = wlen_ext;
    end
  end

  // reading: centre, magnitude, noise floor
  logic signed [11:0]  centred;
  logic [11:0]         mag12;
  logic [SAMPLE_W-1:0] mag;
  logic [SAMPLE_W-1:0] reading_nxt;
  always_comb begin
    centred = $signed({2'b00, in_adc_sample}) - ADC_MID
              - $signed({{2{dc_offset_r[OFS_W-1]}}, dc_offset_r});
    mag12   = centred[11] ? 12'(-centred) : 12'(centred);
    mag     = mag12[SAMPLE_W-1:0];
    reading_nxt = (mag <= noise_floor_r) ? '0 : (mag - noise_floor_r);
  end

  // damped level, 7/8
  logic [19:0]        level_sum;
  logic [LEVEL_W-1:0] level_nxt;
  always_comb begin
    level_sum = 20'({level_r, 3'b000}) - 20'(level_r) + 20'(reading_r);
    level_nxt = level_sum[18:3];
  end

  // write index advance
  logic [LW-1:0] widx_inc;
  logic [AW-1:0] write_idx_nxt;
  always_comb begin
    widx_inc      = LW'(write_idx_r) + LW'(1);
    write_idx_nxt = (widx_inc >= eff_len) ? '0 : widx_inc[AW-1:0];
  end

  // scaled numerator and span
  logic signed [16:0] lvl_diff;
  logic signed [27:0] num_nxt;
  logic signed [16:0] den_nxt;
  always_comb begin
    lvl_diff = $signed({1'b0, level_r}) - $signed({1'b0, avg_low_r});
    num_nxt  = $signed({1'b0, max_height_r}) * lvl_diff;
    den_nxt  = $signed({1'b0, avg_high_r}) - $signed({1'b0, avg_low_r});
  end

  // one restoring division step
  logic [16:0] trial;
  logic        trial_ge;
  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    trial_ge = (trial >= {1'b0, den_r[15:0]});
  end

  // window scan control
  logic scan_more;
  logic scan_done;
  logic div_done;
  assign scan_more = (scan_idx_r < eff_len);
  assign scan_done = !rd_pend_r && !scan_more;
  assign div_done  = (div_cnt_r == '0);

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = write_idx_r;
    mem_wdata = WIN_W'(reading_r);
    mem_raddr = '0;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else if (state_r == S_LEVEL) begin
      mem_we    = 1'b1;
    end
    if (state_r == S_RUN && scan_more) begin
      mem_raddr = scan_idx_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    mem_q_r <= win_mem[mem_raddr];
  end

  // bar height from the division
  logic num_pos;
  logic den_pos;
  logic [HEIGHT_W-1:0] height;
  always_comb begin
    num_pos = !num_r[27] && (num_r != '0);
    den_pos = !den_r[16] && (den_r != '0);
    if (!den_pos) begin
      height = max_height_r;
    end else if (!num_pos) begin
      height = '0;
    end else if (quo_r > DIV_W'(max_height_r)) begin
      height = max_height_r;
    end else begin
      height = quo_r[HEIGHT_W-1:0];
    end
  end

  // peak dot and fall counter
  logic [HEIGHT_W-1:0] peak_nxt;
  logic [RATE_W-1:0]   fall_inc;
  logic [RATE_W-1:0]   fall_cnt_nxt;
  always_comb begin
    peak_nxt = (height > peak_dot_r) ? height : peak_dot_r;
    fall_inc = fall_cnt_r + RATE_W'(1);
    fall_cnt_nxt = fall_inc;
    if (fall_inc >= fall_rate_r) begin
      fall_cnt_nxt = '0;
      if (peak_nxt != '0) begin
        peak_nxt = peak_nxt - HEIGHT_W'(1);
      end
    end
  end

  // bounds with the minimum gap, then 63/64 averaging
  logic [WIN_W-1:0]   span;
  logic [WIN_W:0]     hi_adj;
  logic [22:0]        low_sum;
  logic [22:0]        high_sum;
  logic [LEVEL_W-1:0] avg_low_nxt;
  logic [LEVEL_W-1:0] avg_high_nxt;
  always_comb begin
    span   = hi_r - lo_r;
    hi_adj = (span < WIN_W'(max_height_r)) ? ({1'b0, lo_r} + (WIN_W + 1)'(max_height_r))
                                           : {1'b0, hi_r};
    low_sum  = 23'({avg_low_r, 6'b0}) - 23'(avg_low_r) + 23'(lo_r);
    high_sum = 23'({avg_high_r, 6'b0}) - 23'(avg_high_r) + 23'(hi_adj);
    avg_low_nxt  = low_sum[21:6];
    avg_high_nxt = high_sum[21:6];
  end

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      level_r      <= LEVEL_INIT;
      avg_low_r    <= '0;
      avg_high_r   <= AVG_HIGH_INIT;
      peak_dot_r   <= '0;
      fall_cnt_r   <= '0;
      write_idx_r  <= '0;
      div_cnt_r    <= '0;
      scan_idx_r   <= '0;
      rd_pend_r    <= 1'b0;
      scan_first_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // result taken, unless the finishing step reloads the register
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + AW'(1);
          if (clr_idx_r == AW'(MAX_WINDOW - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            reading_r <= reading_nxt;
            state_r   <= S_LEVEL;
          end
        end
        S_LEVEL: begin
          // reading goes to memory at write_idx this cycle
          level_r     <= level_nxt;
          write_idx_r <= write_idx_nxt;
          state_r     <= S_MUL;
        end
        S_MUL: begin
          num_r   <= num_nxt;
          den_r   <= den_nxt;
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          rem_r        <= '0;
          quo_r        <= num_r[DIV_W-1:0];
          div_cnt_r    <= DCNT_W'(DIV_W);
          scan_idx_r   <= LW'(1);
          rd_pend_r    <= 1'b1;
          scan_first_r <= 1'b1;
          state_r      <= S_RUN;
        end
        S_RUN: begin
          // divider step
          if (!div_done) begin
            rem_r     <= trial_ge ? 16'(trial - {1'b0, den_r[15:0]}) : trial[15:0];
            quo_r     <= {quo_r[DIV_W-2:0], trial_ge};
            div_cnt_r <= div_cnt_r - DCNT_W'(1);
          end
          // issue next window read
          if (scan_more) begin
            scan_idx_r <= scan_idx_r + LW'(1);
            rd_pend_r  <= 1'b1;
          end else begin
            rd_pend_r  <= 1'b0;
          end
          // fold returned entry into min and max
          if (rd_pend_r) begin
            scan_first_r <= 1'b0;
            if (scan_first_r) begin
              lo_r <= mem_q_r;
              hi_r <= mem_q_r;
            end else begin
              if (mem_q_r < lo_r) lo_r <= mem_q_r;
              if (mem_q_r > hi_r) hi_r <= mem_q_r;
            end
          end
          if (div_done && scan_done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_bar_r   <= height;
            out_peak_r  <= peak_nxt;
            peak_dot_r  <= peak_nxt;
            fall_cnt_r  <= fall_cnt_nxt;
            avg_low_r   <= avg_low_nxt;
            avg_high_r  <= avg_high_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  `ARLM_ASSERT_NXT(a_peak_step, 1'b1, (peak_dot_r >= $past(peak_dot_r)) || (peak_dot_r == $past(peak_dot_r) - 10'd1), "peak dot fell by more than one step")
  `ARLM_ASSERT_IMP(a_fin_ready, state_r == S_FIN, div_done && !rd_pend_r && !scan_more, "result stage entered before divider and scan finished")
  `ARLM_ASSERT_IMP(a_out_source, $rose(out_valid_r), $past(state_r == S_FIN), "result appeared outside the finishing step")

endmodule

`default_nettype wire
